>>> sv/scsc_pkg.sv
// Package for the solid color slot cache: sizes, result kinds, controller states,
// and the structs passed between the controller and the table store.
// No dependencies.
`default_nettype none

package scsc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int OUT_SLOT_W  = 10;
    localparam int COLOR_W     = 32;
    localparam int KIND_W      = 3;

    localparam logic [CNT_W-1:0]   DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]   ONE_CNT    = CNT_W'(1);
    localparam logic [SLOT_W-1:0]  SLOT_ZERO  = '0;
    localparam logic [SLOT_W-1:0]  SLOT_ONE   = SLOT_W'(1);
    localparam logic [COLOR_W-1:0] WHITE_ARGB = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0] RGB_MASK   = 32'h00ff_ffff;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ALPHA   = 3'd0,
        KIND_WHITE   = 3'd1,
        KIND_LAST    = 3'd2,
        KIND_HIT     = 3'd3,
        KIND_REVIVED = 3'd4,
        KIND_NEW     = 3'd5,
        KIND_FLUSHED = 3'd6
    } t_kind;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LAST,
        S_SRCH,
        S_MISS,
        S_CLEAR,
        S_APPEND,
        S_EMIT
    } t_state;

    // Controller to store: one shared read port, one write address
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
        logic [SLOT_W-1:0]  wr_addr;
        logic               color_wr_en;
        logic [COLOR_W-1:0] color_wr_data;
        logic               live_wr_en;
        logic               live_wr_data;
    } t_mem_req;

    // Store to controller: registered read data
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               live;
    } t_mem_rsp;

    // One result word
    typedef struct packed {
        t_kind                 kind;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  wrote_back;
        logic                  table_reset;
    } t_result;

    // Table index to the 10-bit result slot (zero extend or keep the low bits)
    function automatic logic [OUT_SLOT_W-1:0] f_out_slot(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+OUT_SLOT_W-1:0] wide;
        wide = {{OUT_SLOT_W{1'b0}}, idx};
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/scsc_if.sv
// Channel interfaces of the solid color slot cache: lookup/flush requests in,
// result words out. Depends on scsc_pkg.
`default_nettype none

interface scsc_in_if import scsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [COLOR_W-1:0] color;
    logic               buffer_on_gpu;

    modport source (output valid, action, color, buffer_on_gpu, input ready);
    modport sink   (input valid, action, color, buffer_on_gpu, output ready);
endinterface

interface scsc_out_if import scsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  wrote_back;
    logic                  table_reset;

    modport source (output valid, kind, slot, wrote_back, table_reset, input ready);
    modport sink   (input valid, kind, slot, wrote_back, table_reset, output ready);
endinterface

`default_nettype wire

>>> sv/solid_color_slot_cache_top.sv
// Top level of the solid color slot cache: controller, table store and the
// output word register. Depends on scsc_pkg, scsc_if, scsc_store, scsc_ctrl.
//
//  channel | dir | handshake       | payload
//  i_in    | in  | valid / ready   | action, color, buffer_on_gpu
//  o_out   | out | valid / ready   | kind, slot, wrote_back, table_reset
//
// One word at a time. Flush, alpha-only and white words pass S_CHECK and S_EMIT
// on the way to the output word register; a last-slot hit also passes S_LAST.
// A search reads one stored color per cycle from the color memory port. A reset
// on a miss that keeps the table size drops handles one slot per cycle.
// Synchronous reset restores the control state; no clearing pass is needed.
// The output register holds one word, so a new word is taken while a result
// waits; the controller stalls only when a second result meets a full register.
`default_nettype none

module solid_color_slot_cache_top import scsc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scsc_in_if.sink    i_in,
    scsc_out_if.source o_out
);

    t_mem_req req;
    t_mem_rsp rsp;
    logic     res_valid;
    logic     res_ready;
    t_result  res;

    logic     r_out_valid;
    t_result  r_out;

    scsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_req       (req),
        .i_rsp       (rsp),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    scsc_store u_store (
        .i_clk (i_clk),
        .i_req (req),
        .o_rsp (rsp)
    );

    // Output word register
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.slot        = r_out.slot;
    assign o_out.wrote_back  = r_out.wrote_back;
    assign o_out.table_reset = r_out.table_reset;

endmodule

`default_nettype wire

>>> sv/scsc_store.sv
// Table store: color memory and handle-live memory, one shared read address
// with registered read data, one write address. Depends on scsc_pkg.
`default_nettype none

module scsc_store import scsc_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_mem_rsp      o_rsp
);

    logic [COLOR_W-1:0] color_mem [TABLE_DEPTH];
    logic               live_mem  [TABLE_DEPTH];
    logic [COLOR_W-1:0] r_color_rd;
    logic               r_live_rd;

    // Color write port
    always_ff @(posedge i_clk) begin
        if (i_req.color_wr_en) begin
            color_mem[i_req.wr_addr] <= i_req.color_wr_data;
        end
    end

    // Live write port
    always_ff @(posedge i_clk) begin
        if (i_req.live_wr_en) begin
            live_mem[i_req.wr_addr] <= i_req.live_wr_data;
        end
    end

    // Registered read of both arrays
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_color_rd <= color_mem[i_req.rd_addr];
            r_live_rd  <= live_mem[i_req.rd_addr];
        end
    end

    assign o_rsp.color = r_color_rd;
    assign o_rsp.live  = r_live_rd;

endmodule

`default_nettype wire

>>> sv/scsc_ctrl.sv
// Lookup controller: classifies a word, checks the last hit slot, walks the
// used slots, and on a miss resets (if full or buffer_on_gpu) and appends. Depends on scsc_pkg, scsc_if.
`default_nettype none

module scsc_ctrl import scsc_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    scsc_in_if.sink        i_in,
    output t_mem_req       o_req,
    input  wire t_mem_rsp  i_rsp,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output t_result        o_res
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [SLOT_W-1:0]  r_last, n_last;
    logic               r_dirty, n_dirty;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic               r_action, n_action;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_gpu, n_gpu;
    t_result            r_res, n_res;

    logic [CNT_W-1:0]   idx_inc;
    logic [SLOT_W-1:0]  idx_next;
    logic [SLOT_W-1:0]  used_slot;
    logic               table_full;
    logic               more_used;

    assign idx_inc    = {1'b0, r_idx} + ONE_CNT;
    assign idx_next   = idx_inc[SLOT_W-1:0];
    assign used_slot  = r_used[SLOT_W-1:0];
    assign table_full = (r_used == DEPTH_CNT);
    assign more_used  = (r_used > ONE_CNT);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= ONE_CNT;
            r_last  <= SLOT_ZERO;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_last  <= n_last;
            r_dirty <= n_dirty;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_action <= n_action;
        r_color  <= n_color;
        r_gpu    <= n_gpu;
        r_res    <= n_res;
    end

    // Next state and memory requests
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_last      = r_last;
        n_dirty     = r_dirty;
        n_idx       = r_idx;
        n_action    = r_action;
        n_color     = r_color;
        n_gpu       = r_gpu;
        n_res       = r_res;
        o_req       = '0;
        i_in.ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_action = i_in.action;
                    n_color  = i_in.color;
                    n_gpu    = i_in.buffer_on_gpu;
                    n_state  = S_CHECK;
                end
            end

            S_CHECK: begin
                n_res.wrote_back  = 1'b0;
                n_res.table_reset = 1'b0;
                n_res.slot        = '0;
                priority if (r_action) begin
                    n_dirty          = 1'b0;
                    n_last           = SLOT_ZERO;
                    n_res.kind       = KIND_FLUSHED;
                    n_res.wrote_back = 1'b1;
                    n_state          = S_EMIT;
                end else if ((r_color & RGB_MASK) == '0) begin
                    n_res.kind = KIND_ALPHA;
                    n_res.slot = {2'b00, r_color[31:24]};
                    n_state    = S_EMIT;
                end else if (r_color == WHITE_ARGB) begin
                    n_res.kind = KIND_WHITE;
                    n_state    = S_EMIT;
                end else if (r_last != SLOT_ZERO) begin
                    // slot 0 stands for white and is never written, so only a nonzero last slot can hit
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_last;
                    n_state       = S_LAST;
                end else if (more_used) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = SLOT_ONE;
                    n_idx         = SLOT_ONE;
                    n_state       = S_SRCH;
                end else begin
                    n_state = S_MISS;
                end
            end

            S_LAST: begin
                priority if (i_rsp.color == r_color) begin
                    n_res.kind = KIND_LAST;
                    n_res.slot = f_out_slot(r_last);
                    n_state    = S_EMIT;
                end else if (more_used) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = SLOT_ONE;
                    n_idx         = SLOT_ONE;
                    n_state       = S_SRCH;
                end else begin
                    n_state = S_MISS;
                end
            end

            // One stored color per cycle; the read of the next slot overlaps the compare
            S_SRCH: begin
                priority if (i_rsp.color == r_color) begin
                    n_res.kind          = i_rsp.live ? KIND_HIT : KIND_REVIVED;
                    n_res.slot          = f_out_slot(r_idx);
                    o_req.live_wr_en    = 1'b1;
                    o_req.live_wr_data  = 1'b1;
                    o_req.wr_addr       = r_idx;
                    n_last              = r_idx;
                    n_state             = S_EMIT;
                end else if (idx_inc < r_used) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = idx_next;
                    n_idx         = idx_next;
                end else begin
                    n_state = S_MISS;
                end
            end

            S_MISS: begin
                if (table_full || r_gpu) begin
                    n_res.wrote_back  = r_dirty;
                    n_res.table_reset = 1'b1;
                    n_dirty           = 1'b0;
                    n_last            = SLOT_ZERO;
                    n_idx             = SLOT_ONE;
                    priority if (table_full) begin
                        n_used  = ONE_CNT;
                        n_state = S_APPEND;
                    end else if (more_used) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    n_state = S_APPEND;
                end
            end

            // Drop handles of used slots 1..used-1, one per cycle
            S_CLEAR: begin
                o_req.live_wr_en   = 1'b1;
                o_req.live_wr_data = 1'b0;
                o_req.wr_addr      = r_idx;
                if (idx_inc < r_used) begin
                    n_idx = idx_next;
                end else begin
                    n_state = S_APPEND;
                end
            end

            S_APPEND: begin
                o_req.wr_addr       = used_slot;
                o_req.color_wr_en   = 1'b1;
                o_req.color_wr_data = r_color;
                o_req.live_wr_en    = 1'b1;
                o_req.live_wr_data  = 1'b1;
                n_used              = r_used + ONE_CNT;
                n_dirty             = 1'b1;
                n_last              = used_slot;
                n_res.kind          = KIND_NEW;
                n_res.slot          = f_out_slot(used_slot);
                n_state             = S_EMIT;
            end

            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
